// ===== hdl/lxep_pkg.sv =====
// Shared types and constants for the LDA exchange energy and potential pipeline.
// No dependencies; every other file in this block imports it.
package lxep_pkg;

	localparam int unsigned LXEP_FRACTION_BITS = 48;
	localparam int unsigned LXEP_DENS_W = 64;
	localparam int unsigned LXEP_SUM_W = 65;
	localparam int unsigned LXEP_X_W = 65;
	localparam int unsigned LXEP_QUOT_W = 61;
	localparam logic [61:0] LXEP_K = 62'd4541334848947935694;

	typedef struct packed {
		logic [LXEP_DENS_W-1:0] total_density;
		logic [LXEP_DENS_W-1:0] up_density;
		logic [LXEP_DENS_W-1:0] down_density;
	} lxep_point_t;

	typedef struct packed {
		logic signed [63:0] energy_density;
		logic signed [63:0] potential_up;
		logic signed [63:0] potential_down;
	} lxep_result_t;

	typedef struct packed {
		logic [LXEP_DENS_W-1:0] up_density;
		logic [LXEP_DENS_W-1:0] down_density;
		logic [LXEP_SUM_W-1:0]  density_sum;
		logic                   single;
	} lxep_side_t;

endpackage

// ===== hdl/lda_exchange_energy_potential.sv =====
// Slater LDA exchange, unpolarized or spin-polarized, one grid point per request.
// Each spin lane has a one-bit-per-stage cube root; energy uses a 61-stage divider.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset clears the pipeline valid bits and spin_polarized to unpolarized mode.
// Depends on lxep_pkg, lxep_front, lxep_cbrt, lxep_kmul and lxep_energy.
module lda_exchange_energy_potential #(
	parameter int unsigned FRACTION_BITS = lxep_pkg::LXEP_FRACTION_BITS,
	localparam int unsigned ROOT_W = (lxep_pkg::LXEP_X_W + 2 * FRACTION_BITS + 2) / 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  lxep_pkg::lxep_point_t  point,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data,
	output logic                   done,
	output lxep_pkg::lxep_result_t result
);
	import lxep_pkg::*;

	localparam int unsigned SIDE_D = ROOT_W + 2;

	logic spin_polarized_q;
	logic fr_valid;
	logic [LXEP_X_W-1:0] x_up, x_dn;
	lxep_side_t fr_side;
	logic cr_valid_up, cr_valid_dn;
	logic [ROOT_W-1:0] root_up, root_dn;
	logic km_valid_up, km_valid_dn;
	logic [ROOT_W-1:0] mag_up, mag_dn;
	lxep_side_t side_s [0:SIDE_D];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_polarized_q <= 1'b0;
		end else if (cfg_valid) begin
			spin_polarized_q <= cfg_data;
		end
	end

	lxep_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.spin_polarized(spin_polarized_q),
		.point(point),
		.out_valid(fr_valid),
		.x_up(x_up),
		.x_dn(x_dn),
		.side(fr_side)
	);

	lxep_cbrt #(.FRACTION_BITS(FRACTION_BITS)) u_cbrt_up (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.x(x_up),
		.out_valid(cr_valid_up),
		.root(root_up)
	);

	lxep_cbrt #(.FRACTION_BITS(FRACTION_BITS)) u_cbrt_dn (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.x(x_dn),
		.out_valid(cr_valid_dn),
		.root(root_dn)
	);

	lxep_kmul #(.FRACTION_BITS(FRACTION_BITS)) u_kmul_up (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cr_valid_up),
		.root(root_up),
		.out_valid(km_valid_up),
		.mag(mag_up)
	);

	lxep_kmul #(.FRACTION_BITS(FRACTION_BITS)) u_kmul_dn (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cr_valid_dn),
		.root(root_dn),
		.out_valid(km_valid_dn),
		.mag(mag_dn)
	);

	assign side_s[0] = fr_side;

	for (genvar k = 0; k < SIDE_D; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	lxep_energy #(.FRACTION_BITS(FRACTION_BITS)) u_energy (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(km_valid_up),
		.side(side_s[SIDE_D]),
		.mag_up(mag_up),
		.mag_dn(mag_dn),
		.out_valid(done),
		.result(result)
	);

	// Both spin lanes carry the same request in lockstep.
	a_lane_align: assert property (@(posedge clk) disable iff (!arst_n)
		km_valid_up == km_valid_dn)
		else $error("spin lanes out of step");

	// Exchange potentials and energy are never positive.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.potential_up <= 0 && result.potential_down <= 0
			&& result.energy_density <= 0))
		else $error("positive exchange result");

endmodule

// ===== hdl/lxep_front.sv =====
// Input stage: mode select, density floor and spin sum for one grid point.
// Depends on lxep_pkg.
module lxep_front #(
	parameter int unsigned FRACTION_BITS = lxep_pkg::LXEP_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               spin_polarized,
	input  lxep_pkg::lxep_point_t              point,
	output logic                               out_valid,
	output logic [lxep_pkg::LXEP_X_W-1:0]      x_up,
	output logic [lxep_pkg::LXEP_X_W-1:0]      x_dn,
	output lxep_pkg::lxep_side_t               side
);
	import lxep_pkg::*;

	localparam logic [63:0] FLOOR_RAW =
		((64'd1 << FRACTION_BITS) + 64'd50000000000000) / 64'd100000000000000;
	localparam logic [63:0] FLOOR = (FLOOR_RAW == 64'd0) ? 64'd1 : FLOOR_RAW;

	logic [LXEP_SUM_W-1:0] sum;
	logic [LXEP_DENS_W-1:0] tot_fl;
	logic [LXEP_X_W-1:0] xu, xd;
	logic single;

	logic valid_s1;
	logic [LXEP_X_W-1:0] x_up_s1, x_dn_s1;
	lxep_side_t side_s1;

	always_comb begin
		sum = {1'b0, point.up_density} + {1'b0, point.down_density};
		tot_fl = (point.total_density <= FLOOR) ? FLOOR : point.total_density;
		if (!spin_polarized) begin
			xu = {1'b0, tot_fl};
			xd = {1'b0, tot_fl};
			single = 1'b1;
		end else if (sum <= {1'b0, FLOOR}) begin
			xu = {1'b0, FLOOR};
			xd = {1'b0, FLOOR};
			single = 1'b1;
		end else begin
			xu = {point.up_density, 1'b0};
			xd = {point.down_density, 1'b0};
			single = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_up_s1 <= xu;
		x_dn_s1 <= xd;
		side_s1.up_density <= point.up_density;
		side_s1.down_density <= point.down_density;
		side_s1.density_sum <= sum;
		side_s1.single <= single;
	end

	assign out_valid = valid_s1;
	assign x_up = x_up_s1;
	assign x_dn = x_dn_s1;
	assign side = side_s1;

endmodule

// ===== hdl/lxep_cbrt.sv =====
// Pipelined digit-recurrence cube root, one result bit per stage.
// Depends on lxep_pkg.
module lxep_cbrt #(
	parameter int unsigned FRACTION_BITS = lxep_pkg::LXEP_FRACTION_BITS,
	localparam int unsigned ROOT_W = (lxep_pkg::LXEP_X_W + 2 * FRACTION_BITS + 2) / 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [lxep_pkg::LXEP_X_W-1:0] x,
	output logic                          out_valid,
	output logic [ROOT_W-1:0]             root
);
	import lxep_pkg::*;

	localparam int unsigned TP = 3 * ROOT_W;
	localparam int unsigned RW = 2 * ROOT_W + 3;

	logic                  v_s  [0:ROOT_W];
	logic [LXEP_X_W-1:0]   x_s  [0:ROOT_W];
	logic [ROOT_W-1:0]     y_s  [0:ROOT_W];
	logic [2*ROOT_W-1:0]   y2_s [0:ROOT_W];
	logic [RW-1:0]         r_s  [0:ROOT_W];

	assign v_s[0] = in_valid;
	assign x_s[0] = x;
	assign y_s[0] = '0;
	assign y2_s[0] = '0;
	assign r_s[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [TP-1:0] tgt;
		logic [RW-1:0] yd, y2d, rn, t;
		logic ge;

		assign tgt = TP'(x_s[k]) << (2 * FRACTION_BITS);
		assign yd = RW'(y_s[k]) << 1;
		assign y2d = RW'(y2_s[k]) << 2;
		assign rn = {r_s[k][RW-4:0], tgt[TP-1-3*k -: 3]};
		assign t = (y2d << 1) + y2d + (yd << 1) + yd + RW'(1);
		assign ge = (rn >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			x_s[k+1] <= x_s[k];
			y_s[k+1] <= {y_s[k][ROOT_W-2:0], ge};
			if (ge) begin
				r_s[k+1] <= rn - t;
				y2_s[k+1] <= (2*ROOT_W)'(y2d + (yd << 1) + RW'(1));
			end else begin
				r_s[k+1] <= rn;
				y2_s[k+1] <= (2*ROOT_W)'(y2d);
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root = y_s[ROOT_W];

	// The remainder left by the recurrence never reaches the next cube step.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ROOT_W] |-> (r_s[ROOT_W] <= (RW'(y2_s[ROOT_W]) << 1) + RW'(y2_s[ROOT_W])
			+ (RW'(y_s[ROOT_W]) << 1) + RW'(y_s[ROOT_W])))
		else $error("cube root remainder out of range");

endmodule

// ===== hdl/lxep_kmul.sv =====
// Scales a cube root by (3/pi)^(1/3) with rounding, as four registered partial products.
// Depends on lxep_pkg.
module lxep_kmul #(
	parameter int unsigned FRACTION_BITS = lxep_pkg::LXEP_FRACTION_BITS,
	localparam int unsigned ROOT_W = (lxep_pkg::LXEP_X_W + 2 * FRACTION_BITS + 2) / 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] root,
	output logic              out_valid,
	output logic [ROOT_W-1:0] mag
);
	import lxep_pkg::*;

	localparam int unsigned FW = ROOT_W + 64;
	localparam logic [31:0] K_LO = LXEP_K[31:0];
	localparam logic [29:0] K_HI = LXEP_K[61:32];

	logic [31:0] rl;
	logic [ROOT_W-33:0] rh;
	logic [FW-1:0] full;

	logic valid_s1, valid_s2;
	logic [63:0] pll_s1, plh_s1, phl_s1, phh_s1;
	logic [ROOT_W-1:0] mag_s2;

	assign rl = root[31:0];
	assign rh = root[ROOT_W-1:32];

	always_comb begin
		full = FW'(pll_s1) + ((FW'(plh_s1) + FW'(phl_s1)) << 32) + (FW'(phh_s1) << 64)
			+ (FW'(1) << 61);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pll_s1 <= 64'(rl) * 64'(K_LO);
		plh_s1 <= 64'(rl) * 64'(K_HI);
		phl_s1 <= 64'(rh) * 64'(K_LO);
		phh_s1 <= 64'(rh) * 64'(K_HI);
		mag_s2 <= full[62 +: ROOT_W];
	end

	assign out_valid = valid_s2;
	assign mag = mag_s2;

endmodule

// ===== hdl/lxep_energy.sv =====
// Energy per particle: weighted products, pipelined restoring divider and output negation.
// Depends on lxep_pkg.
module lxep_energy #(
	parameter int unsigned FRACTION_BITS = lxep_pkg::LXEP_FRACTION_BITS,
	localparam int unsigned ROOT_W = (lxep_pkg::LXEP_X_W + 2 * FRACTION_BITS + 2) / 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  lxep_pkg::lxep_side_t   side,
	input  logic [ROOT_W-1:0]      mag_up,
	input  logic [ROOT_W-1:0]      mag_dn,
	output logic                   out_valid,
	output lxep_pkg::lxep_result_t result
);
	import lxep_pkg::*;

	localparam int unsigned PW = 64 + ROOT_W;
	localparam int unsigned NW = PW + 3;
	localparam int unsigned DW = LXEP_SUM_W + 2;
	localparam int unsigned QB = LXEP_QUOT_W;
	localparam int unsigned CW = (NW > DW + QB - 1) ? NW : DW + QB - 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic sg_s1, sg_s2, sg_s3, sg_s4;
	logic [LXEP_SUM_W-1:0] sum_s1, sum_s2, sum_s3, sum_s4;
	logic [ROOT_W-1:0] em_s1, em_s2, em_s3, em_s4;
	logic [ROOT_W-1:0] mu_s1, mu_s2, mu_s3, mu_s4;
	logic [ROOT_W-1:0] mw_s1, mw_s2, mw_s3, mw_s4;
	logic [63:0] ull_s1, ulh_s1, uhl_s1, uhh_s1;
	logic [63:0] dll_s1, dlh_s1, dhl_s1, dhh_s1;
	logic [PW-1:0] pu_s2, pd_s2;
	logic [PW:0] pt_s3;
	logic [NW-1:0] num_s4;

	logic                  dv_s   [0:QB];
	logic                  dsg_s  [0:QB];
	logic [ROOT_W-1:0]     dem_s  [0:QB];
	logic [ROOT_W-1:0]     dmu_s  [0:QB];
	logic [ROOT_W-1:0]     dmw_s  [0:QB];
	logic [DW-1:0]         dden_s [0:QB];
	logic [CW-1:0]         drem_s [0:QB];
	logic [QB-1:0]         dq_s   [0:QB];

	logic out_valid_q;
	lxep_result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= dv_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		ull_s1 <= 64'(side.up_density[31:0]) * 64'(mag_up[31:0]);
		ulh_s1 <= 64'(side.up_density[31:0]) * 64'(mag_up[ROOT_W-1:32]);
		uhl_s1 <= 64'(side.up_density[63:32]) * 64'(mag_up[31:0]);
		uhh_s1 <= 64'(side.up_density[63:32]) * 64'(mag_up[ROOT_W-1:32]);
		dll_s1 <= 64'(side.down_density[31:0]) * 64'(mag_dn[31:0]);
		dlh_s1 <= 64'(side.down_density[31:0]) * 64'(mag_dn[ROOT_W-1:32]);
		dhl_s1 <= 64'(side.down_density[63:32]) * 64'(mag_dn[31:0]);
		dhh_s1 <= 64'(side.down_density[63:32]) * 64'(mag_dn[ROOT_W-1:32]);
		em_s1 <= ROOT_W'((((ROOT_W+2)'(mag_up) << 1) + (ROOT_W+2)'(mag_up)
			+ (ROOT_W+2)'(2)) >> 2);
		sg_s1 <= side.single;
		sum_s1 <= side.density_sum;
		mu_s1 <= mag_up;
		mw_s1 <= mag_dn;

		pu_s2 <= PW'(ull_s1) + ((PW'(ulh_s1) + PW'(uhl_s1)) << 32) + (PW'(uhh_s1) << 64);
		pd_s2 <= PW'(dll_s1) + ((PW'(dlh_s1) + PW'(dhl_s1)) << 32) + (PW'(dhh_s1) << 64);
		sg_s2 <= sg_s1;
		sum_s2 <= sum_s1;
		em_s2 <= em_s1;
		mu_s2 <= mu_s1;
		mw_s2 <= mw_s1;

		pt_s3 <= (PW+1)'(pu_s2) + (PW+1)'(pd_s2);
		sg_s3 <= sg_s2;
		sum_s3 <= sum_s2;
		em_s3 <= em_s2;
		mu_s3 <= mu_s2;
		mw_s3 <= mw_s2;

		num_s4 <= (NW'(pt_s3) << 1) + NW'(pt_s3) + (NW'(sum_s3) << 1);
		sg_s4 <= sg_s3;
		sum_s4 <= sum_s3;
		em_s4 <= em_s3;
		mu_s4 <= mu_s3;
		mw_s4 <= mw_s3;
	end

	assign dv_s[0] = v_s4;
	assign dsg_s[0] = sg_s4;
	assign dem_s[0] = em_s4;
	assign dmu_s[0] = mu_s4;
	assign dmw_s[0] = mw_s4;
	assign dden_s[0] = DW'(sum_s4) << 2;
	assign drem_s[0] = CW'(num_s4);
	assign dq_s[0] = '0;

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [CW-1:0] sh;
		logic ge;

		assign sh = CW'(dden_s[j]) << (QB - 1 - j);
		assign ge = (sh <= drem_s[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dsg_s[j+1] <= dsg_s[j];
			dem_s[j+1] <= dem_s[j];
			dmu_s[j+1] <= dmu_s[j];
			dmw_s[j+1] <= dmw_s[j];
			dden_s[j+1] <= dden_s[j];
			drem_s[j+1] <= ge ? (drem_s[j] - sh) : drem_s[j];
			dq_s[j+1] <= {dq_s[j][QB-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		result_q.energy_density <= dsg_s[QB] ? (64'd0 - 64'(dem_s[QB]))
			: (64'd0 - 64'(dq_s[QB]));
		result_q.potential_up <= 64'd0 - 64'(dmu_s[QB]);
		result_q.potential_down <= 64'd0 - 64'(dmw_s[QB]);
	end

	assign out_valid = out_valid_q;
	assign result = result_q;

	// For a two-spin request the quotient always fits, so the final remainder is below
	// the divisor. Single-density requests do not use the quotient.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_s[QB] && !dsg_s[QB]) |-> (drem_s[QB] < CW'(dden_s[QB])))
		else $error("divider remainder not below divisor");

endmodule

// ===== tb/lda_exchange_energy_potential_tb.sv =====
// Self-checking testbench for lda_exchange_energy_potential, unpolarized and spin-polarized.
// Computes the exchange energy and potentials independently and compares every result.
// Depends on lxep_pkg and the lda_exchange_energy_potential RTL.
module lda_exchange_energy_potential_tb;
	import lxep_pkg::*;

	localparam int unsigned DENSITY_FLOOR = 3;
	localparam int unsigned DRAIN_CYCLES = 140;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic MODE_TOTAL = 1'b0;
	localparam logic MODE_SPIN = 1'b1;

	class exchange_scoreboard;
		lxep_result_t pending[$];
		int unsigned errors;
		int unsigned checked;

		function void note(lxep_result_t predicted);
			pending.push_back(predicted);
		endfunction

		function void check(lxep_result_t actual);
			lxep_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, actual);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (actual.energy_density !== want.energy_density) begin
				$display("%0t: energy_density expected %h actual %h", $time,
					want.energy_density, actual.energy_density);
				errors++;
			end
			if (actual.potential_up !== want.potential_up) begin
				$display("%0t: potential_up expected %h actual %h", $time,
					want.potential_up, actual.potential_up);
				errors++;
			end
			if (actual.potential_down !== want.potential_down) begin
				$display("%0t: potential_down expected %h actual %h", $time,
					want.potential_down, actual.potential_down);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lxep_point_t point = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic done;
	lxep_result_t result;

	logic busy_s = 1'b1;
	logic cfg_ready_s = 1'b0;
	logic spin_mode = MODE_TOTAL;
	int unsigned cycles = 0;
	int unsigned total_count = 0;
	int unsigned spin_count = 0;
	exchange_scoreboard board = new();

	lda_exchange_energy_potential DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		busy_s <= busy;
		cfg_ready_s <= cfg_ready;
		if (arst_n && done === 1'b1)
			board.check(result);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("lda_exchange_energy_potential_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] potential_magnitude(logic [64:0] x);
		logic [191:0] target;
		logic [191:0] trial;
		logic [191:0] prod;
		logic [59:0] root;
		target = {127'b0, x} << 96;
		root = '0;
		for (int b = 59; b >= 0; b--) begin
			trial = {132'b0, root} | (192'd1 << b);
			if (trial * trial * trial <= target)
				root = trial[59:0];
		end
		prod = {130'b0, LXEP_K} * {132'b0, root} + (192'd1 << 61);
		return prod[125:62];
	endfunction

	function automatic lxep_result_t predict_exchange(lxep_point_t p, logic spin);
		lxep_result_t r;
		logic [64:0] dens;
		logic [64:0] sum;
		logic [63:0] mag_up;
		logic [63:0] mag_dn;
		logic [191:0] num;
		logic [191:0] den;
		logic [191:0] quot;
		sum = {1'b0, p.up_density} + {1'b0, p.down_density};
		if (spin == MODE_TOTAL || sum <= DENSITY_FLOOR) begin
			if (spin == MODE_TOTAL)
				dens = p.total_density <= DENSITY_FLOOR ? DENSITY_FLOOR : {1'b0, p.total_density};
			else
				dens = DENSITY_FLOOR;
			mag_up = potential_magnitude(dens);
			r.energy_density = -((3 * mag_up + 2) >> 2);
			r.potential_up = -mag_up;
			r.potential_down = -mag_up;
			return r;
		end
		mag_up = potential_magnitude({p.up_density, 1'b0});
		mag_dn = potential_magnitude({p.down_density, 1'b0});
		num = 192'(p.up_density) * 192'(mag_up) + 192'(p.down_density) * 192'(mag_dn);
		num = num * 3 + (192'(sum) << 1);
		den = 192'(sum) << 2;
		quot = num / den;
		r.energy_density = -quot[63:0];
		r.potential_up = -mag_up;
		r.potential_down = -mag_dn;
		return r;
	endfunction

	function automatic logic [63:0] random_density();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(0, 8));
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	task automatic send_point(lxep_point_t p);
		int unsigned gap;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy_s);
		board.note(predict_exchange(p, spin_mode));
		if (spin_mode == MODE_SPIN)
			spin_count++;
		else
			total_count++;
	endtask

	task automatic send_densities(logic [63:0] t, logic [63:0] u, logic [63:0] d);
		lxep_point_t p;
		p.total_density = t;
		p.up_density = u;
		p.down_density = d;
		send_point(p);
	endtask

	task automatic write_mode(logic m);
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready_s);
		cfg_valid <= 1'b0;
		spin_mode = m;
	endtask

	task automatic send_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_densities(random_density(), random_density(), random_density());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_densities(64'd0, {$urandom, $urandom}, {$urandom, $urandom});
		send_densities(64'd1, 64'd0, 64'd0);
		send_densities(64'd3, 64'd0, 64'd0);
		send_densities(64'd4, 64'd0, 64'd0);
		send_densities({64{1'b1}}, 64'd0, 64'd0);
		send_densities(64'h0001_0000_0000_0000, 64'd5, 64'd5);
		send_densities(64'h8000_0000_0000_0000, 64'd0, 64'd0);

		write_mode(MODE_SPIN);
		send_densities({$urandom, $urandom}, 64'd0, 64'd0);
		send_densities(64'd0, 64'd3, 64'd0);
		send_densities(64'd0, 64'd1, 64'd2);
		send_densities(64'd0, 64'd2, 64'd2);
		send_densities(64'd0, 64'd4, 64'd0);
		send_densities(64'd0, 64'd0, 64'd4);
		send_densities(64'd0, {64{1'b1}}, {64{1'b1}});
		send_densities(64'd0, {64{1'b1}}, 64'd0);
		send_densities(64'd0, 64'd0, {64{1'b1}});
		send_densities(64'd0, 64'h0001_0000_0000_0000, 64'h0001_0000_0000_0000);
		send_densities(64'd0, 64'h0001_0000_0000_0000, 64'd1);
		send_densities(64'd1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);

		for (int ph = 0; ph < 4; ph++) begin
			write_mode(ph % 2 == 0 ? MODE_TOTAL : MODE_SPIN);
			send_random(230);
		end

		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d unpolarized and %0d spin-polarized requests, %0d results checked.",
			total_count, spin_count, board.checked);
		if (board.errors == 0)
			$display("lda_exchange_energy_potential_tb: PASS");
		else
			$display("lda_exchange_energy_potential_tb: FAIL");
		$finish;
	end
endmodule
